/* hw/rtl/atsa_pkg.sv */
package atsa_pkg;

    // arctangent table, degrees with 16 fraction bits
    localparam int TAB_FRAC = 16;
    localparam int TAB_LEN  = 24;
    localparam int ZW       = 26;

    function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
        case (i)
            5'd0:  atan_tab = 26'sd2949120;
            5'd1:  atan_tab = 26'sd1740967;
            5'd2:  atan_tab = 26'sd919879;
            5'd3:  atan_tab = 26'sd466945;
            5'd4:  atan_tab = 26'sd234379;
            5'd5:  atan_tab = 26'sd117304;
            5'd6:  atan_tab = 26'sd58666;
            5'd7:  atan_tab = 26'sd29335;
            5'd8:  atan_tab = 26'sd14668;
            5'd9:  atan_tab = 26'sd7334;
            5'd10: atan_tab = 26'sd3667;
            5'd11: atan_tab = 26'sd1833;
            5'd12: atan_tab = 26'sd917;
            5'd13: atan_tab = 26'sd458;
            5'd14: atan_tab = 26'sd229;
            5'd15: atan_tab = 26'sd115;
            5'd16: atan_tab = 26'sd57;
            5'd17: atan_tab = 26'sd29;
            5'd18: atan_tab = 26'sd14;
            5'd19: atan_tab = 26'sd7;
            5'd20: atan_tab = 26'sd4;
            5'd21: atan_tab = 26'sd2;
            5'd22: atan_tab = 26'sd1;
            default: atan_tab = 26'sd0;
        endcase
    endfunction

endpackage

/* hw/rtl/atsa_isqrt.sv */
// pipelined restoring square root, one result bit per stage
module atsa_isqrt
    import atsa_pkg::*;
#(
    parameter int IW = 48,
    parameter int TW = 8
)
(
    input  logic            clk,
    input  logic            en,
    input  logic [IW-1:0]   radicand,
    input  logic [TW-1:0]   tag_in,
    output logic [IW/2-1:0] root,
    output logic [TW-1:0]   tag_out
);
    localparam int N = IW / 2;

    logic [IW-1:0] rem_reg  [0:N];
    logic [IW-1:0] res_reg  [0:N];
    logic [IW-1:0] bit_reg  [0:N];
    logic [TW-1:0] tag_reg  [0:N];

    // stage 0 loads the operand
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= radicand;
            res_reg[0] <= '0;
            bit_reg[0] <= {2'b01, {(IW-2){1'b0}}};
            tag_reg[0] <= tag_in;
        end
    end

    // one digit per stage
    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [IW-1:0] sum;
        assign sum = res_reg[s] + bit_reg[s];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[s] >= sum)
                begin
                    rem_reg[s+1] <= rem_reg[s] - sum;
                    res_reg[s+1] <= (res_reg[s] >> 1) + bit_reg[s];
                end
                else
                begin
                    rem_reg[s+1] <= rem_reg[s];
                    res_reg[s+1] <= res_reg[s] >> 1;
                end
                bit_reg[s+1] <= bit_reg[s] >> 2;
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    assign root    = res_reg[N][N-1:0];
    assign tag_out = tag_reg[N];
endmodule

/* hw/rtl/atsa_cordic.sv */
// pipelined vectoring cordic, atan2(num, den) in degrees
module atsa_cordic
    import atsa_pkg::*;
#(
    parameter int STAGES    = 16,
    parameter int FRAC_BITS = 8,
    parameter int DW        = 26
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [DW-1:0]  num,
    input  logic [DW-2:0]         den,
    output logic signed [ZW-1:0]  angle
);
    localparam int NS  = (STAGES < TAB_LEN) ? STAGES : TAB_LEN;
    localparam int XW  = DW + 2;
    localparam logic signed [ZW-1:0] LIM = ZW'(90 << FRAC_BITS);

    // special case marks carried down the pipeline
    localparam logic [1:0] SP_NONE = 2'd0;
    localparam logic [1:0] SP_ZERO = 2'd1;
    localparam logic [1:0] SP_POS  = 2'd2;
    localparam logic [1:0] SP_NEG  = 2'd3;

    logic signed [XW-1:0] x_reg [0:NS];
    logic signed [XW-1:0] y_reg [0:NS];
    logic signed [ZW-1:0] z_reg [0:NS];
    logic [1:0]           sp_reg [0:NS];
    logic signed [ZW-1:0] out_reg;

    // special cases: zero numerator, zero denominator
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= XW'($signed({1'b0, den}));
            y_reg[0]   <= XW'(num);
            z_reg[0]   <= '0;
            if (num == '0)
                sp_reg[0] <= SP_ZERO;
            else if (den == '0)
                sp_reg[0] <= num[DW-1] ? SP_NEG : SP_POS;
            else
                sp_reg[0] <= SP_NONE;
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_tab(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_tab(5'(i));
                end
                sp_reg[i+1] <= sp_reg[i];
            end
        end
    end

    // round to output fraction bits and clamp
    logic signed [ZW-1:0] zr;
    logic signed [ZW-1:0] zc;
    always_comb
    begin
        if (TAB_FRAC > FRAC_BITS)
            zr = (z_reg[NS] + ZW'(1 << (TAB_FRAC - FRAC_BITS - 1)))
                 >>> (TAB_FRAC - FRAC_BITS);
        else
            zr = z_reg[NS];
        if (zr > LIM)
            zc = LIM;
        else if (zr < -LIM)
            zc = -LIM;
        else
            zc = zr;
        case (sp_reg[NS])
            SP_ZERO: zc = '0;
            SP_POS:  zc = LIM;
            SP_NEG:  zc = -LIM;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= zc;
    end

    assign angle = out_reg;
endmodule

/* hw/rtl/accel_tilt_servo_alert_top.sv */
// Tilt sensor: one accelerometer sample (x, y, z) per beat gives pitch, roll,
// servo command (pitch + 90 clamped to 0..180) and a tilt alert when |pitch| or
// |roll| exceeds alert_threshold. Fully pipelined: a new beat every cycle
// while the output is not stalled. A result passes the input register,
// 1 square stage, 25 square root stages, CORDIC_STAGES + 2 cordic stages
// (CORDIC_STAGES capped at 24) and the output register. The whole
// pipeline advances when the output register is free or being taken.
module accel_tilt_servo_alert_top
    import atsa_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_STAGES   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // pitch_deg, roll_deg, servo_deg, tilt_alert
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata
);
    localparam int NS  = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int LAT = 1 + 1 + 25 + NS + 2 + 1;
    localparam int SW  = ZW + 1;

    logic [14:0] thr_reg;
    logic [LAT-1:0] vld_reg;
    logic en;

    // pipeline advances when output slot free or drained
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 15'(30 << ANGLE_FRAC_BITS);
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    // input register
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= s_axis_tdata[15:0];
            ay_reg <= s_axis_tdata[31:16];
            az_reg <= s_axis_tdata[47:32];
        end
    end

    // squares
    logic [31:0] xx_reg, yy_reg, zz_reg;
    logic signed [15:0] ax1_reg, ay1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg  <= 32'(ax_reg) * 32'(ax_reg);
            yy_reg  <= 32'(ay_reg) * 32'(ay_reg);
            zz_reg  <= 32'(az_reg) * 32'(az_reg);
            ax1_reg <= ax_reg;
            ay1_reg <= ay_reg;
        end
    end

    // sum of squares never exceeds 2^31, so 32 bits hold it
    logic [47:0] rad_p, rad_r;
    assign rad_p = {yy_reg + zz_reg, 16'd0};
    assign rad_r = {xx_reg + zz_reg, 16'd0};

    logic [23:0] den_p, den_r;
    logic [15:0] tp_out, tr_out;

    atsa_isqrt #(.IW(48), .TW(16)) u_sqrt_p (
        .clk(clk), .en(en), .radicand(rad_p), .tag_in(ax1_reg),
        .root(den_p), .tag_out(tp_out));
    atsa_isqrt #(.IW(48), .TW(16)) u_sqrt_r (
        .clk(clk), .en(en), .radicand(rad_r), .tag_in(ay1_reg),
        .root(den_r), .tag_out(tr_out));

    logic signed [ZW-1:0] pitch, roll;

    atsa_cordic #(.STAGES(CORDIC_STAGES), .FRAC_BITS(ANGLE_FRAC_BITS), .DW(25))
        u_cor_p (.clk(clk), .en(en), .num({tp_out[15], tp_out, 8'd0}),
                 .den(den_p), .angle(pitch));
    atsa_cordic #(.STAGES(CORDIC_STAGES), .FRAC_BITS(ANGLE_FRAC_BITS), .DW(25))
        u_cor_r (.clk(clk), .en(en), .num({tr_out[15], tr_out, 8'd0}),
                 .den(den_r), .angle(roll));

    // servo, alert and output register
    logic signed [SW-1:0] servo;
    logic [ZW-1:0] ap, ar;
    logic [15:0] sv;
    logic        alert;
    always_comb
    begin
        servo = SW'(pitch) + SW'(90 << ANGLE_FRAC_BITS);
        if (servo < 0)
            sv = '0;
        else if (servo > SW'(180 << ANGLE_FRAC_BITS))
            sv = 16'(180 << ANGLE_FRAC_BITS);
        else
            sv = servo[15:0];
        ap = pitch < 0 ? ZW'(-pitch) : ZW'(pitch);
        ar = roll < 0 ? ZW'(-roll) : ZW'(roll);
        alert = (ap > ZW'(thr_reg)) || (ar > ZW'(thr_reg));
    end

    logic [48:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= {alert, sv, roll[15:0], pitch[15:0]};
    end

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = {7'd0, out_reg};
endmodule

/* hw/rtl/atsa_checker.sv */
module atsa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_servo: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:32] <= 16'd46080)
        else $error("servo out of range");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:49] == 7'd0)
        else $error("padding not zero");
endmodule

bind accel_tilt_servo_alert_top atsa_checker u_chk (.*);
